[design/size_class_free_list_allocator_defines.svh]
// ----------------------------------------------------------------------------
// size class allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SFLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfla check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfla check failed");

`endif

[design/sfla_pkg.sv]
// ----------------------------------------------------------------------------
// sfla_pkg
// shared types and codes of the size class allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam logic [19:0] NULL_MARK = 20'hFFFFF;
  localparam int          SUM_W     = 22;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SYS = 2'd1;
  localparam logic [1:0] STAT_OOM = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_REFILL,
    S_CARVE
  } state_e;

endpackage

[design/sfla_link_ram.sv]
// ----------------------------------------------------------------------------
// sfla_link_ram
// single port link memory, registered read data
// ----------------------------------------------------------------------------
module sfla_link_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 20
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[design/size_class_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// segregated free list pool allocator with links held in a link memory
// ----------------------------------------------------------------------------
// free and too-large items finish in S_DECIDE, a pop in S_POP, out of memory in S_REFILL,
//   a refill in S_CARVE, which links one carved object per step
// a new item is accepted only in S_IDLE, once the previous one is done; every pop,
//   push and carve step goes through the single link memory port
// reset: chunk pointers and bytes obtained clear, class heads go null, arena limit 524288,
//   link memory not cleared; the receiver cannot stall, each result is one cycle on done_o
module size_class_free_list_allocator #(
  parameter int ALIGN_BYTES    = 8,
  parameter int NUM_CLASSES    = 16,
  parameter int REFILL_OBJECTS = 32,
  parameter int ARENA_WORDS    = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] request_size_i,
  input  logic [18:0] object_address_i,
  // result side
  output logic        done_o,
  output logic [18:0] granted_address_o,
  output logic [1:0]  status_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i
);
  import sfla_pkg::*;

  // align and arena depth are taken as powers of two
  localparam int SH      = $clog2(ALIGN_BYTES);
  localparam int CLW     = $clog2(NUM_CLASSES);
  localparam int AW      = $clog2(ARENA_WORDS);
  localparam int KW      = $clog2(REFILL_OBJECTS + 1);
  localparam int THRESH  = NUM_CLASSES * ALIGN_BYTES;
  localparam int CAP_RAW = ARENA_WORDS * ALIGN_BYTES;
  localparam int CAP     = (CAP_RAW < 524288) ? CAP_RAW : 524288;

  // size class of a byte count, clamped to the last class
  function automatic logic [CLW-1:0] class_of(input logic [15:0] sz);
    logic [16:0] q;
    q = (17'(sz) + 17'(ALIGN_BYTES - 1)) >> SH;
    if (sz == 16'd0) begin
      class_of = '0;
    end else if (q > 17'(NUM_CLASSES)) begin
      class_of = CLW'(NUM_CLASSES - 1);
    end else begin
      class_of = CLW'(q - 17'd1);
    end
  endfunction

  // link memory word of a byte address
  function automatic logic [AW-1:0] word_of(input logic [19:0] a);
    word_of = AW'(a >> SH);
  endfunction

  state_e state_q, state_d;

  // latched item
  logic             kind_q;
  logic [15:0]      size_q;
  logic [18:0]      addr_q;
  logic [CLW-1:0]   cls_q, cls_d;

  // pool state
  logic [19:0]      arena_q;
  logic [19:0]      chunk_start_q, chunk_start_d;
  logic [19:0]      chunk_end_q, chunk_end_d;
  logic [19:0]      bo_q, bo_d;
  logic [19:0]      heads_q [NUM_CLASSES];

  // refill working registers
  logic [19:0]      n_q, n_d;
  logic [19:0]      total_q, total_d;
  logic [19:0]      left_q, left_d;
  logic [20:0]      bo_round_q, bo_round_d;
  logic [19:0]      cur_q, cur_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [KW-1:0]    k_q, k_d;

  // result registers
  logic             done_q, done_d;
  logic [18:0]      res_addr_q, res_addr_d;
  logic [1:0]       res_stat_q, res_stat_d;

  // class head port
  logic [CLW-1:0]   hidx;
  logic [19:0]      head_rd;
  logic             head_we;
  logic [CLW-1:0]   head_widx;
  logic [19:0]      head_wdata;

  // link memory port
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [19:0]      ram_wdata;
  logic [19:0]      ram_rdata;

  // combinational helpers
  logic [CLW-1:0]   cls_c;
  logic [CLW-1:0]   lc_c;
  logic [SUM_W-1:0] get_c;
  logic [SUM_W-1:0] need_c;
  logic [SUM_W-1:0] limit_c;
  logic             exists_c;
  logic             next_c;
  logic [SUM_W-1:0] rem_less_c;

  assign cls_c      = class_of(size_q);
  assign lc_c       = class_of(left_q[15:0]);
  assign get_c      = (SUM_W'(total_q) << 1) + SUM_W'(bo_round_q);
  assign need_c     = SUM_W'(bo_q) + get_c;
  assign limit_c    = (arena_q < 20'(CAP)) ? SUM_W'(arena_q) : SUM_W'(CAP);
  assign exists_c   = (k_q < KW'(REFILL_OBJECTS)) && (rem_q >= SUM_W'(n_q));
  assign rem_less_c = rem_q - SUM_W'(n_q);
  assign next_c     = (SUM_W'(k_q) + SUM_W'(1) < SUM_W'(REFILL_OBJECTS))
                      && (rem_less_c >= SUM_W'(n_q));

  // one read index into the class heads
  always_comb begin
    unique case (state_q)
      S_DECIDE: hidx = cls_c;
      S_REFILL: hidx = lc_c;
      default:  hidx = cls_q;
    endcase
  end
  assign head_rd = heads_q[hidx];

  sfla_link_ram #(
    .DEPTH (ARENA_WORDS),
    .AW    (AW),
    .DW    (20)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (size_q > 16'(THRESH) || kind_q == KIND_FREE) begin
          state_d = S_IDLE;
        end else if (head_rd != NULL_MARK) begin
          state_d = S_POP;
        end else begin
          state_d = S_REFILL;
        end
      end
      S_POP: state_d = S_IDLE;
      S_REFILL: begin
        if (left_q < n_q && need_c > limit_c) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_CARVE;
        end
      end
      S_CARVE: begin
        if (!exists_c || !next_c) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cls_d         = cls_q;
    chunk_start_d = chunk_start_q;
    chunk_end_d   = chunk_end_q;
    bo_d          = bo_q;
    n_d           = n_q;
    total_d       = total_q;
    left_d        = left_q;
    bo_round_d    = bo_round_q;
    cur_d         = cur_q;
    rem_d         = rem_q;
    k_d           = k_q;
    done_d        = 1'b0;
    res_addr_d    = res_addr_q;
    res_stat_d    = res_stat_q;
    head_we       = 1'b0;
    head_widx     = cls_q;
    head_wdata    = head_rd;
    ram_we        = 1'b0;
    ram_addr      = word_of(cur_q);
    ram_wdata     = head_rd;
    unique case (state_q)
      S_IDLE: ;
      S_DECIDE: begin
        cls_d      = cls_c;
        n_d        = (20'(cls_c) + 20'd1) << SH;
        total_d    = 20'(((20'(cls_c) + 20'd1) << SH) * 20'(REFILL_OBJECTS));
        left_d     = (chunk_end_q >= chunk_start_q) ? chunk_end_q - chunk_start_q : 20'd0;
        bo_round_d = (21'(bo_q) + 21'(ALIGN_BYTES - 1)) & ~21'(ALIGN_BYTES - 1);
        res_addr_d = 19'd0;
        res_stat_d = STAT_OK;
        if (size_q > 16'(THRESH)) begin
          // pass to the system allocator
          done_d     = 1'b1;
          res_stat_d = STAT_SYS;
        end else if (kind_q == KIND_FREE) begin
          // push onto the class list
          done_d     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = word_of({1'b0, addr_q});
          ram_wdata  = head_rd;
          head_we    = 1'b1;
          head_widx  = cls_c;
          head_wdata = {1'b0, addr_q};
        end else begin
          // pop reads the link of the head, refill falls through
          ram_addr   = word_of(head_rd);
          res_addr_d = head_rd[18:0];
        end
      end
      S_POP: begin
        done_d     = 1'b1;
        head_we    = 1'b1;
        head_widx  = cls_q;
        head_wdata = ram_rdata;
      end
      S_REFILL: begin
        if (left_q >= n_q) begin
          // carve from the current chunk
          res_addr_d = chunk_start_q[18:0];
          cur_d      = chunk_start_q + n_q;
          rem_d      = SUM_W'(left_q) - SUM_W'(n_q);
          k_d        = KW'(1);
        end else if (need_c > limit_c) begin
          // out of memory, pool left untouched
          done_d     = 1'b1;
          res_addr_d = 19'd0;
          res_stat_d = STAT_OOM;
        end else begin
          // file the leftover, then bump a new chunk
          if (left_q != 20'd0) begin
            ram_we     = 1'b1;
            ram_addr   = word_of(chunk_start_q);
            ram_wdata  = head_rd;
            head_we    = 1'b1;
            head_widx  = lc_c;
            head_wdata = chunk_start_q;
          end
          bo_d       = 20'(need_c);
          chunk_end_d = 20'(SUM_W'(bo_q) + get_c);
          res_addr_d = bo_q[18:0];
          cur_d      = bo_q + n_q;
          rem_d      = get_c - SUM_W'(n_q);
          k_d        = KW'(1);
        end
      end
      S_CARVE: begin
        if (!exists_c) begin
          // only the granted object fits
          done_d        = 1'b1;
          chunk_start_d = cur_q;
        end else begin
          if (k_q == KW'(1)) begin
            head_we    = 1'b1;
            head_widx  = cls_q;
            head_wdata = cur_q;
          end
          ram_we    = 1'b1;
          ram_addr  = word_of(cur_q);
          ram_wdata = next_c ? cur_q + n_q : NULL_MARK;
          cur_d     = cur_q + n_q;
          k_d       = k_q + KW'(1);
          rem_d     = rem_less_c;
          if (!next_c) begin
            done_d        = 1'b1;
            chunk_start_d = cur_q + n_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      arena_q       <= 20'd524288;
      chunk_start_q <= '0;
      chunk_end_q   <= '0;
      bo_q          <= '0;
      done_q        <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_q[i] <= NULL_MARK;
      end
    end else begin
      state_q       <= state_d;
      chunk_start_q <= chunk_start_d;
      chunk_end_q   <= chunk_end_d;
      bo_q          <= bo_d;
      done_q        <= done_d;
      if (cfg_we_i) begin
        arena_q <= cfg_wdata_i;
      end
      if (head_we) begin
        heads_q[head_widx] <= head_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      kind_q <= kind_i;
      size_q <= request_size_i;
      addr_q <= object_address_i;
    end
    cls_q      <= cls_d;
    n_q        <= n_d;
    total_q    <= total_d;
    left_q     <= left_d;
    bo_round_q <= bo_round_d;
    cur_q      <= cur_d;
    rem_q      <= rem_d;
    k_q        <= k_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign granted_address_o = res_addr_q;
  assign status_o          = res_stat_q;

endmodule

[design/sfla_checker.sv]
// ----------------------------------------------------------------------------
// sfla_checker
// port level checks on the size class allocator
// ----------------------------------------------------------------------------
`include "size_class_free_list_allocator_defines.svh"

module sfla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [18:0] granted_address_o,
  input logic [1:0]  status_o
);
  import sfla_pkg::*;

  `SFLA_ASSERT_NOW(a_stat_code, done_o, status_o == STAT_OK || status_o == STAT_SYS || status_o == STAT_OOM)
  `SFLA_ASSERT_NOW(a_fail_zero, done_o && status_o != STAT_OK, granted_address_o == 19'd0)
  `SFLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SFLA_ASSERT_NEXT(a_single_strobe, done_o, !done_o)

endmodule

bind size_class_free_list_allocator sfla_checker u_sfla_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the size class free list allocator: a clocked
// driver presents allocate and free items, a clocked monitor compares each
// result with a cycle-free model of the pool kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sfla_pkg::*;

  localparam int unsigned ALIGN     = 8;
  localparam int unsigned CLASSES   = 16;
  localparam int unsigned CARVE_MAX = 32;
  localparam int unsigned WORDS     = 65536;
  localparam int unsigned THRESHOLD = CLASSES * ALIGN;
  localparam int          IDLE_PCT  = 30;
  localparam int          WDOG_MAX  = 4000;
  localparam int          SETTLE    = 80;   // covers the longest refill walk

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [18:0] addr;
    bit          drain;   // hold off until every result is back
    bit          quiet;   // part of the stretch with no idle cycles
  } item_t;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [18:0] grant;
    logic [1:0]  status;
  } outcome_t;

  typedef struct {
    logic [18:0] addr;
    logic [15:0] size;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [18:0] object_address_i = '0;
  logic        done_o;
  logic [18:0] granted_address_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;

  // pool model state
  logic [19:0] arena_limit;
  logic [19:0] carve_ptr;
  logic [19:0] carve_end;
  logic [19:0] obtained;
  logic [19:0] heads [CLASSES];
  logic [19:0] links [WORDS];

  item_t    pending [$];
  outcome_t awaited [$];
  block_t   live [$];
  item_t    cur;
  int       err_count = 0;
  int       wdog = 0;

  always #2 clk_i = ~clk_i;

  size_class_free_list_allocator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .request_size_i   (request_size_i),
    .object_address_i (object_address_i),
    .done_o           (done_o),
    .granted_address_o(granted_address_o),
    .status_o         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------- pool model
  function automatic int unsigned class_index(int unsigned sz);
    int unsigned idx;
    if (sz == 0) return 0;
    idx = (sz + ALIGN - 1) / ALIGN - 1;
    if (idx >= CLASSES) idx = CLASSES - 1;
    return idx;
  endfunction

  function automatic int unsigned usable_bytes();
    int unsigned lim;
    lim = arena_limit;
    if (WORDS * ALIGN < lim) lim = WORDS * ALIGN;
    if (32'h80000 < lim) lim = 32'h80000;
    return lim;
  endfunction

  function automatic void push_block(int unsigned cls, int unsigned a);
    links[(a / ALIGN) % WORDS] = heads[cls];
    heads[cls] = a[19:0];
  endfunction

  // empty class: carve from the chunk or bump a new one; 0 when out of arena
  function automatic bit carve_class(int unsigned cls, output logic [18:0] grant);
    int unsigned n, count, total, left, base, get, cur_a;
    n     = (cls + 1) * ALIGN;
    count = CARVE_MAX;
    total = n * count;
    left  = (carve_end < carve_ptr) ? 0 : carve_end - carve_ptr;
    grant = '0;
    if (left > total) begin
      base = carve_ptr;
    end else if (left >= n) begin
      count = left / n;
      total = n * count;
      base  = carve_ptr;
    end else begin
      get = 2 * total + ((obtained + ALIGN - 1) / ALIGN) * ALIGN;
      if (obtained + get > usable_bytes()) return 1'b0;
      // leftover of the old chunk goes to its own class first
      if (left > 0) push_block(class_index(left), carve_ptr);
      base      = obtained;
      obtained  = obtained + get[19:0];
      carve_end = base[19:0] + get[19:0];
    end
    carve_ptr = base[19:0] + total[19:0];
    grant     = base[18:0];
    if (count > 1) begin
      cur_a = base + n;
      heads[cls] = cur_a[19:0];
      for (int unsigned i = 1; i + 1 < count; i++) begin
        links[(cur_a / ALIGN) % WORDS] = (cur_a + n) & 32'hFFFFF;
        cur_a += n;
      end
      links[(cur_a / ALIGN) % WORDS] = NULL_MARK;
    end
    return 1'b1;
  endfunction

  function automatic outcome_t serve_request(item_t it);
    outcome_t    o;
    int unsigned cls;
    logic [19:0] head;
    o.kind   = it.kind;
    o.size   = it.size;
    o.grant  = '0;
    o.status = STAT_OK;
    if (it.size > THRESHOLD) begin
      o.status = STAT_SYS;
    end else begin
      cls = class_index(it.size);
      if (it.kind == KIND_FREE) begin
        push_block(cls, it.addr);
      end else begin
        head = heads[cls];
        if (head != NULL_MARK) begin
          heads[cls] = links[(head / ALIGN) % WORDS];
          o.grant = head[18:0];
        end else if (!carve_class(cls, o.grant)) begin
          o.status = STAT_OOM;
          o.grant  = '0;
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      bit take_next;
      // an accepted item is modelled at once, in the order of acceptance
      if (start && !busy) awaited.push_back(serve_request(cur));
      take_next = !start || !busy;
      if (take_next) begin
        if (pending.size() == 0 ||
            (pending[0].drain && (awaited.size() != 0 || (start && !busy))) ||
            (!pending[0].quiet && $urandom_range(99) < IDLE_PCT)) begin
          start <= 1'b0;
        end else begin
          cur = pending.pop_front();
          start            <= 1'b1;
          kind_i           <= cur.kind;
          request_size_i   <= cur.size;
          object_address_i <= cur.addr;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result", int'(granted_address_o), 0);
      end else begin
        outcome_t w;
        w = awaited.pop_front();
        if (status_o !== w.status)
          report_mismatch("status", int'(status_o), int'(w.status));
        if (granted_address_o !== w.grant)
          report_mismatch("granted_address", int'(granted_address_o), int'(w.grant));
        // remember granted blocks so later frees hand back real objects
        if (w.kind == KIND_ALLOC && w.status == STAT_OK && live.size() < 200) begin
          block_t b;
          b.addr = w.grant;
          b.size = w.size;
          live.push_back(b);
        end
      end
    end
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_item(logic k, logic [15:0] sz, logic [18:0] a,
                          bit drain = 0, bit quiet = 0);
    item_t it;
    it.kind = k; it.size = sz; it.addr = a; it.drain = drain; it.quiet = quiet;
    pending.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending.size() != 0 || start || awaited.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_arena(logic [19:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    arena_limit = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly allocations and frees of live blocks, some raw noise
  task automatic random_phase(int count, int quiet_from, int quiet_to);
    int pick, idx;
    logic [15:0] sz;
    bit q;
    for (int i = 0; i < count; i++) begin
      while (pending.size() > 3) @(posedge clk_i);
      q    = (i >= quiet_from && i < quiet_to);
      pick = $urandom_range(99);
      if (pick < 50) begin
        sz = ($urandom_range(3) == 0) ? 16'($urandom_range(THRESHOLD))
                                      : 16'($urandom_range(32));
        add_item(KIND_ALLOC, sz, 19'($urandom), 0, q);
      end else if (pick < 85 && live.size() > 0) begin
        idx = $urandom_range(live.size() - 1);
        add_item(KIND_FREE, live[idx].size, live[idx].addr, 0, q);
        live.delete(idx);
      end else begin
        add_item(1'($urandom_range(1)), 16'($urandom), 19'($urandom), 0, q);
      end
    end
  endtask

  initial begin
    arena_limit = 20'd524288;
    carve_ptr   = '0;
    carve_end   = '0;
    obtained    = '0;
    for (int i = 0; i < CLASSES; i++) heads[i] = NULL_MARK;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest arena: no refill fits, so only pushed objects can be popped
    write_arena(20'd64);
    add_item(KIND_ALLOC, 16'd8, '0);            // out of memory
    add_item(KIND_ALLOC, 16'd129, '0);          // just above the threshold
    add_item(KIND_FREE, 16'hFFFF, 19'h7FFFF);   // too large, ignored
    add_item(KIND_FREE, 16'd0, 19'h7FFFF);      // misaligned free, size zero
    add_item(KIND_ALLOC, 16'd0, 19'h7FFFF);     // pops it back
    add_item(KIND_FREE, 16'd128, 19'h12345);
    add_item(KIND_ALLOC, 16'd128, '0);
    add_item(KIND_FREE, 16'd1, '0);
    add_item(KIND_ALLOC, 16'd1, '0);
    add_item(KIND_ALLOC, 16'd1, '0, 1);         // list empty again, out of memory
    wait_idle();

    write_arena(20'd4096);
    add_item(KIND_ALLOC, 16'd8, '0);
    add_item(KIND_ALLOC, 16'd128, '0);          // carved from the rest of the current chunk
    add_item(KIND_ALLOC, 16'd65535, '0);
    random_phase(130, 40, 90);
    wait_idle();

    write_arena(20'd524288);
    random_phase(150, 0, 20);
    wait_idle();

    write_arena(20'd300000);
    random_phase(120, 60, 110);
    add_item(KIND_ALLOC, 16'd16, '0, 1);
    wait_idle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
